@@ rtl/wbc_pkg.sv @@
// Shared types, constants and arithmetic helpers of the Bezier curve evaluator.
package wbc_pkg;

  // Default sizes handed to the top level.
  localparam int KEY_WORDS_DEF    = 128;
  localparam int NEWTON_STEPS_DEF = 3;

  // Largest word offset a segment can reach: 3 * 63 + 3, plus one.
  localparam int ADDR_SPAN = 193;
  localparam int SPAN_W    = $clog2(ADDR_SPAN);

  // Divider operand widths: a Q16.16 difference scaled by 2^16, and a divisor.
  localparam int NUM_W = 50;
  localparam int DEN_W = 34;

  // Command codes.
  localparam logic [1:0] CMD_WRX  = 2'd0;
  localparam logic [1:0] CMD_WRY  = 2'd1;
  localparam logic [1:0] CMD_EVAL = 2'd2;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [6:0]         word_addr;
    logic signed [31:0] word_data;
    logic [5:0]         segment;
    logic signed [31:0] x_query;
  } req_t;

  typedef struct packed {
    logic signed [31:0] y_value;
    logic               degenerate;
  } rsp_t;

  // Everything an item carries along the solver pipeline.
  typedef struct packed {
    q_t   xq;
    q_t   h0;
    q_t   h1;
    q_t   h2;
    q_t   h3;
    q_t   g0;
    q_t   g1;
    q_t   g2;
    q_t   g3;
    q_t   u;
    logic degen;
    logic skip;
  } ctx_t;

  // Saturate a wide signed value to the Q16.16 range.
  function automatic q_t sat_q(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

  // Round a raw Q32.32 product to Q16.16, half up, without saturation.
  function automatic logic signed [47:0] rnd(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t[63:16];
  endfunction

  // Elaboration-time wrap of a word offset into the table.
  function automatic int wrap_val(input int v, input int n);
    int r;
    r = v;
    while (r >= n) begin
      r = r - n;
    end
    return r;
  endfunction

endpackage

@@ rtl/wbc_div.sv @@
// Pipelined restoring divider giving a saturated Q16.16 quotient, one bit per stage.
module wbc_div
  import wbc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  input  ctx_t                    in_ctx,
  output logic                    out_valid,
  output q_t                      quo,
  output ctx_t                    out_ctx
);

  localparam int QB = 33;

  typedef struct packed {
    logic                valid;
    logic [NUM_W-2:0]    rem;
    logic [DEN_W-2:0]    dm;
    logic [QB-1:0]       qb;
    logic                neg;
    logic                ovf;
    ctx_t                ctx;
  } dstage_t;

  dstage_t st [QB+1];

  logic [NUM_W-1:0] num_abs;
  logic [DEN_W-1:0] den_abs;

  // Magnitudes of the operands.
  always_comb begin
    num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    den_abs = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  end

  // Set-up stage: signs, magnitudes and the overflow test.
  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (en) begin
      st[0].valid <= in_valid;
      st[0].rem   <= num_abs[NUM_W-2:0];
      st[0].dm    <= den_abs[DEN_W-2:0];
      st[0].qb    <= '0;
      st[0].neg   <= num[NUM_W-1] ^ den[DEN_W-1];
      st[0].ovf   <= 66'(num_abs[NUM_W-2:0]) >= (66'(den_abs[DEN_W-2:0]) << QB);
      st[0].ctx   <= in_ctx;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < QB; j++) begin : g_bit
    logic [65:0] shifted;
    logic        take;
    dstage_t     stage_next;
    assign shifted = 66'(st[j].dm) << (QB - 1 - j);
    assign take    = 66'(st[j].rem) >= shifted;

    // Subtract the shifted divisor where it fits and set the matching bit.
    always_comb begin
      stage_next = st[j];
      if (take) begin
        stage_next.rem = st[j].rem - (NUM_W-1)'(shifted);
        stage_next.qb  = st[j].qb | (QB'(1) << (QB - 1 - j));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[j+1].valid <= 1'b0;
      end else if (en) begin
        st[j+1] <= stage_next;
      end
    end
  end

  logic signed [QB:0] q_signed;
  q_t                 q_sat;

  // Apply the sign, then saturate.
  always_comb begin
    q_signed = st[QB].neg ? -$signed({1'b0, st[QB].qb}) : $signed({1'b0, st[QB].qb});
    if (st[QB].ovf) begin
      q_sat = st[QB].neg ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      q_sat = sat_q(64'(q_signed));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st[QB].valid;
      quo       <= q_sat;
      out_ctx   <= st[QB].ctx;
    end
  end

endmodule

@@ rtl/wbc_newton.sv @@
// One pipelined Newton refinement step of the curve parameter.
module wbc_newton
  import wbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  ctx_t in_ctx,
  output logic out_valid,
  output ctx_t out_ctx
);

  logic               a_valid, b_valid, c_valid, d_valid, e_valid, f_valid;
  ctx_t               a_ctx, b_ctx, c_ctx, d_ctx, e_ctx, f_ctx;
  logic signed [63:0] a_uu, a_h1u, a_h2u;
  q_t                 b_u2;
  logic signed [47:0] b_h1u, b_h2u;
  logic signed [63:0] c_u2u, c_h1u2, c_h0u2;
  logic signed [47:0] c_h1u, c_h2u;
  q_t                 d_u3, d_der;
  logic signed [47:0] d_h1u2, d_h2u;
  logic signed [63:0] e_h0u3;
  logic signed [47:0] e_h1u2, e_h2u;
  q_t                 e_der;
  q_t                 f_fx, f_der;

  // Stage A: products of u.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      a_ctx   <= in_ctx;
      a_uu    <= 64'(in_ctx.u) * 64'(in_ctx.u);
      a_h1u   <= 64'(in_ctx.h1) * 64'(in_ctx.u);
      a_h2u   <= 64'(in_ctx.h2) * 64'(in_ctx.u);
    end
  end

  // Stage B: round u^2 and the linear terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
      b_ctx   <= a_ctx;
      b_u2    <= sat_q(64'(rnd(a_uu)));
      b_h1u   <= rnd(a_h1u);
      b_h2u   <= rnd(a_h2u);
    end
  end

  // Stage C: products of u^2.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
      c_ctx   <= b_ctx;
      c_u2u   <= 64'(b_u2) * 64'(b_ctx.u);
      c_h1u2  <= 64'(b_ctx.h1) * 64'(b_u2);
      c_h0u2  <= 64'(b_ctx.h0) * 64'(b_u2);
      c_h1u   <= b_h1u;
      c_h2u   <= b_h2u;
    end
  end

  // Stage D: u^3 and the derivative.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
      d_ctx   <= c_ctx;
      d_u3    <= sat_q(64'(rnd(c_u2u)));
      d_h1u2  <= rnd(c_h1u2);
      d_h2u   <= c_h2u;
      d_der   <= sat_q(64'(rnd(c_h0u2)) * 64'sd3 + 64'(c_h1u) * 64'sd2 + 64'(c_ctx.h2));
    end
  end

  // Stage E: cubic term product.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
      e_ctx   <= d_ctx;
      e_h0u3  <= 64'(d_ctx.h0) * 64'(d_u3);
      e_h1u2  <= d_h1u2;
      e_h2u   <= d_h2u;
      e_der   <= d_der;
    end
  end

  // Stage F: x(u).
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
      f_ctx   <= e_ctx;
      f_fx    <= sat_q(64'(rnd(e_h0u3)) + 64'(e_h1u2) + 64'(e_h2u) + 64'(e_ctx.h3));
      f_der   <= e_der;
    end
  end

  logic                    der_zero;
  logic signed [NUM_W-1:0] dv_num;
  logic signed [DEN_W-1:0] dv_den;
  ctx_t                    dv_ctx;

  // Divider operands; a zero derivative divides by one and is discarded.
  always_comb begin
    der_zero     = (f_der == 32'sd0);
    dv_num       = NUM_W'((64'(f_fx) - 64'(f_ctx.xq)) <<< 16);
    dv_den       = der_zero ? DEN_W'(1) : DEN_W'(f_der);
    dv_ctx       = f_ctx;
    dv_ctx.skip  = der_zero;
    dv_ctx.degen = f_ctx.degen | der_zero;
  end

  logic dq_valid;
  q_t   dq;
  ctx_t dq_ctx;

  wbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .num      (dv_num),
    .den      (dv_den),
    .in_ctx   (dv_ctx),
    .out_valid(dq_valid),
    .quo      (dq),
    .out_ctx  (dq_ctx)
  );

  q_t   u_next;
  ctx_t out_ctx_next;

  // Update u unless the derivative was zero.
  always_comb begin
    u_next         = dq_ctx.skip ? dq_ctx.u : sat_q(64'(dq_ctx.u) - 64'(dq));
    out_ctx_next   = dq_ctx;
    out_ctx_next.u = u_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dq_valid;
      out_ctx   <= out_ctx_next;
    end
  end

endmodule

@@ rtl/weighted_bezier_curve_eval.sv @@
// Top level of the cubic Bezier keyframe evaluator with a Newton solve.
//
//  channel | direction | handshake        | payload
//  req     | in        | req_valid / stall| req_t: cmd, word_addr, word_data, segment, x_query
//  rsp     | out       | rsp_valid / stall| rsp_t: y_value, degenerate
//
// One item enters per cycle while req_stall is low; an evaluate passes through the
// bit-per-stage dividers (35 stages each) in the guess and in every Newton step.
// Writes land in the key tables at their transfer.
// Reset is synchronous and clears the valid bits only; the tables are not cleared.
// A stalled result is held, one more may enter a skid register, and then the whole
// pipeline freezes and req_stall rises until the skid register drains.
module weighted_bezier_curve_eval
  import wbc_pkg::*;
#(
  parameter int KEY_WORDS    = KEY_WORDS_DEF,
  parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int AW = $clog2(KEY_WORDS);

  logic adv;
  logic accept;
  logic skid_valid;
  rsp_t skid;

  assign adv       = !skid_valid;
  assign req_stall = skid_valid;
  assign accept    = req_valid && adv;

  // Constant table that wraps a word offset into the key tables.
  logic [AW-1:0] wrap_lut [ADDR_SPAN];
  for (genvar i = 0; i < ADDR_SPAN; i++) begin : g_wrap
    assign wrap_lut[i] = AW'(wrap_val(i, KEY_WORDS));
  end

  logic [AW-1:0]     waddr;
  logic              in_range;
  logic              wr_x, wr_y;
  logic [AW-1:0]     raddr [4];
  logic [SPAN_W-1:0] span_idx [4];
  q_t                px [4];
  q_t                py [4];

  assign waddr    = AW'(req.word_addr);
  assign in_range = 32'(req.word_addr) < KEY_WORDS;
  assign wr_x     = accept && (req.cmd == CMD_WRX) && in_range;
  assign wr_y     = accept && (req.cmd == CMD_WRY) && in_range;

  // Four replicated banks per table, one per control point read.
  for (genvar k = 0; k < 4; k++) begin : g_bank
    q_t xm [KEY_WORDS];
    q_t ym [KEY_WORDS];

    assign span_idx[k] = SPAN_W'({req.segment, 1'b0}) + SPAN_W'(req.segment) + SPAN_W'(k);
    assign raddr[k]    = wrap_lut[span_idx[k]];

    always_ff @(posedge clk) begin
      if (wr_x) begin
        xm[waddr] <= req.word_data;
      end
      if (wr_y) begin
        ym[waddr] <= req.word_data;
      end
      if (adv) begin
        px[k] <= xm[raddr[k]];
        py[k] <= ym[raddr[k]];
      end
    end
  end

  logic t0_valid;
  q_t   t0_xq;

  // Stage 0: table read, alongside the query.
  always_ff @(posedge clk) begin
    if (rst) begin
      t0_valid <= 1'b0;
    end else if (adv) begin
      t0_valid <= accept && (req.cmd == CMD_EVAL);
      t0_xq    <= req.x_query;
    end
  end

  logic                    t1_valid;
  ctx_t                    t1_ctx;
  logic signed [NUM_W-1:0] t1_num;
  logic signed [DEN_W-1:0] t1_den;
  logic                    span_zero;

  assign span_zero = (px[3] == px[0]);

  // Stage 1: power-basis coefficients and the linear guess operands.
  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else if (adv) begin
      t1_valid     <= t0_valid;
      t1_ctx.xq    <= t0_xq;
      t1_ctx.h0    <= sat_q(-64'(px[0]) + 64'sd3 * 64'(px[1]) - 64'sd3 * 64'(px[2])
                            + 64'(px[3]));
      t1_ctx.h1    <= sat_q(64'sd3 * 64'(px[0]) - 64'sd6 * 64'(px[1]) + 64'sd3 * 64'(px[2]));
      t1_ctx.h2    <= sat_q(-64'sd3 * 64'(px[0]) + 64'sd3 * 64'(px[1]));
      t1_ctx.h3    <= px[0];
      t1_ctx.g0    <= sat_q(-64'(py[0]) + 64'sd3 * 64'(py[1]) - 64'sd3 * 64'(py[2])
                            + 64'(py[3]));
      t1_ctx.g1    <= sat_q(64'sd3 * 64'(py[0]) - 64'sd6 * 64'(py[1]) + 64'sd3 * 64'(py[2]));
      t1_ctx.g2    <= sat_q(-64'sd3 * 64'(py[0]) + 64'sd3 * 64'(py[1]));
      t1_ctx.g3    <= py[0];
      t1_ctx.u     <= '0;
      t1_ctx.degen <= span_zero;
      t1_ctx.skip  <= span_zero;
      t1_num       <= NUM_W'((64'(t0_xq) - 64'(px[0])) <<< 16);
      t1_den       <= span_zero ? DEN_W'(1) : DEN_W'(64'(px[3]) - 64'(px[0]));
    end
  end

  logic gd_valid;
  q_t   gd_q;
  ctx_t gd_ctx;

  wbc_div u_guess_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (t1_valid),
    .num      (t1_num),
    .den      (t1_den),
    .in_ctx   (t1_ctx),
    .out_valid(gd_valid),
    .quo      (gd_q),
    .out_ctx  (gd_ctx)
  );

  logic chain_valid [NEWTON_STEPS+1];
  ctx_t chain_ctx   [NEWTON_STEPS+1];
  ctx_t guess_ctx_next;

  // Initial u, zero when the segment spans no x.
  always_comb begin
    guess_ctx_next   = gd_ctx;
    guess_ctx_next.u = gd_ctx.skip ? 32'sd0 : gd_q;
  end

  // Stage 2: register the initial u.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (adv) begin
      chain_valid[0] <= gd_valid;
      chain_ctx[0]   <= guess_ctx_next;
    end
  end

  // Newton refinement chain.
  for (genvar s = 0; s < NEWTON_STEPS; s++) begin : g_step
    wbc_newton u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (chain_valid[s]),
      .in_ctx   (chain_ctx[s]),
      .out_valid(chain_valid[s+1]),
      .out_ctx  (chain_ctx[s+1])
    );
  end

  logic               y1_valid, y2_valid, y3_valid, y4_valid, y5_valid, y6_valid;
  ctx_t               y1_ctx, y2_ctx, y3_ctx, y4_ctx, y5_ctx;
  logic signed [63:0] y1_uu, y1_g2u;
  q_t                 y2_u2;
  logic signed [47:0] y2_g2u;
  logic signed [63:0] y3_u2u, y3_g1u2;
  logic signed [47:0] y3_g2u;
  q_t                 y4_u3;
  logic signed [47:0] y4_g1u2, y4_g2u;
  logic signed [63:0] y5_g0u3;
  logic signed [47:0] y5_g1u2, y5_g2u;
  rsp_t               y6;

  // Evaluation of y(u): products, rounding, powers and the final sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      y1_valid <= 1'b0;
      y2_valid <= 1'b0;
      y3_valid <= 1'b0;
      y4_valid <= 1'b0;
      y5_valid <= 1'b0;
      y6_valid <= 1'b0;
    end else if (adv) begin
      y1_valid <= chain_valid[NEWTON_STEPS];
      y2_valid <= y1_valid;
      y3_valid <= y2_valid;
      y4_valid <= y3_valid;
      y5_valid <= y4_valid;
      y6_valid <= y5_valid;

      y1_ctx  <= chain_ctx[NEWTON_STEPS];
      y1_uu   <= 64'(chain_ctx[NEWTON_STEPS].u) * 64'(chain_ctx[NEWTON_STEPS].u);
      y1_g2u  <= 64'(chain_ctx[NEWTON_STEPS].g2) * 64'(chain_ctx[NEWTON_STEPS].u);

      y2_ctx  <= y1_ctx;
      y2_u2   <= sat_q(64'(rnd(y1_uu)));
      y2_g2u  <= rnd(y1_g2u);

      y3_ctx  <= y2_ctx;
      y3_u2u  <= 64'(y2_u2) * 64'(y2_ctx.u);
      y3_g1u2 <= 64'(y2_ctx.g1) * 64'(y2_u2);
      y3_g2u  <= y2_g2u;

      y4_ctx  <= y3_ctx;
      y4_u3   <= sat_q(64'(rnd(y3_u2u)));
      y4_g1u2 <= rnd(y3_g1u2);
      y4_g2u  <= y3_g2u;

      y5_ctx  <= y4_ctx;
      y5_g0u3 <= 64'(y4_ctx.g0) * 64'(y4_u3);
      y5_g1u2 <= y4_g1u2;
      y5_g2u  <= y4_g2u;

      y6.y_value    <= sat_q(64'(rnd(y5_g0u3)) + 64'(y5_g1u2) + 64'(y5_g2u)
                             + 64'(y5_ctx.g3));
      y6.degenerate <= y5_ctx.degen;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp        <= skid;
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp        <= y6;
        rsp_valid  <= y6_valid;
      end
    end else if (adv && y6_valid) begin
      skid       <= y6;
      skid_valid <= 1'b1;
    end
  end

endmodule

@@ bench/tb_weighted_bezier_curve_eval.sv @@
// Self-checking testbench for the Bezier keyframe evaluator with its Newton solve.
`timescale 1ns / 1ps

module tb_weighted_bezier_curve_eval
  import wbc_pkg::*;
();

  localparam int TAB_WORDS = 128;
  localparam int DRAIN_CYCLES = 250;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 370;
  localparam int REQ_W = $bits(req_t);
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  weighted_bezier_curve_eval uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // Shadow copy of the key tables and the queue of predicted curve points.
  longint x_tab[TAB_WORDS];
  longint y_tab[TAB_WORDS];
  rsp_t   pending_points[$];
  int     fail_count = 0;
  int     burst_left = 0;
  int     quiet_cycles = 0;
  int     stall_tick = 0;

  // Clock: 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Saturate to the signed 32-bit range.
  function automatic longint sat_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product, rounded half up, not saturated.
  function automatic longint fix_mul(input longint a, input longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  // Q16.16 quotient truncated toward zero, then saturated.
  function automatic longint fix_div(input longint num, input longint den);
    return sat_word((num * 64'sd65536) / den);
  endfunction

  // Power-basis coefficients of one cubic segment.
  function automatic void bezier_coeffs(input longint p[4], output longint c[4]);
    c[0] = sat_word(-p[0] + 3 * p[1] - 3 * p[2] + p[3]);
    c[1] = sat_word(3 * p[0] - 6 * p[1] + 3 * p[2]);
    c[2] = sat_word(-3 * p[0] + 3 * p[1]);
    c[3] = p[0];
  endfunction

  function automatic longint cubic_at(input longint c[4], input longint u3,
                                      input longint u2, input longint u);
    return sat_word(fix_mul(c[0], u3) + fix_mul(c[1], u2) + fix_mul(c[2], u) + c[3]);
  endfunction

  // Predicted curve point for one evaluate transfer.
  function automatic rsp_t solve_segment(input logic [5:0] seg, input longint xq);
    longint px[4];
    longint py[4];
    longint h[4];
    longint g[4];
    longint u;
    longint u2;
    longint u3;
    longint f;
    longint d;
    bit     dg;
    rsp_t   r;
    dg = 1'b0;
    for (int k = 0; k < 4; k++) begin
      px[k] = x_tab[(int'(seg) * 3 + k) % TAB_WORDS];
      py[k] = y_tab[(int'(seg) * 3 + k) % TAB_WORDS];
    end
    // A flat chord gives no linear guess.
    if (px[3] == px[0]) begin
      u = 0;
      dg = 1'b1;
    end else begin
      u = fix_div(xq - px[0], px[3] - px[0]);
    end
    bezier_coeffs(px, h);
    for (int s = 0; s < NEWTON_STEPS_DEF; s++) begin
      u2 = sat_word(fix_mul(u, u));
      u3 = sat_word(fix_mul(u2, u));
      f = cubic_at(h, u3, u2, u);
      d = sat_word(3 * fix_mul(h[0], u2) + 2 * fix_mul(h[1], u) + h[2]);
      // A zero slope leaves u where it is.
      if (d == 0) begin
        dg = 1'b1;
      end else begin
        u = sat_word(u - fix_div(f - xq, d));
      end
    end
    bezier_coeffs(py, g);
    u2 = sat_word(fix_mul(u, u));
    u3 = sat_word(fix_mul(u2, u));
    r.y_value = 32'(cubic_at(g, u3, u2, u));
    r.degenerate = dg;
    return r;
  endfunction

  // Update the shadow tables or queue a prediction for an accepted request.
  function automatic void track_request(input req_t r);
    if (r.cmd == CMD_WRX) begin
      x_tab[r.word_addr] = longint'(r.word_data);
    end else if (r.cmd == CMD_WRY) begin
      y_tab[r.word_addr] = longint'(r.word_data);
    end else if (r.cmd == CMD_EVAL) begin
      pending_points.push_back(solve_segment(r.segment, longint'(r.x_query)));
    end
  endfunction

  // Send one request, with bursts and random gaps between them.
  task automatic send_item(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        req_valid <= 1'b0;
      end
    end
    @(negedge clk);
    req <= r;
    req_valid <= 1'b1;
    burst_left--;
    do @(posedge clk); while (req_stall);
    track_request(r);
  endtask

  // Build a request with random contents in the fields the command ignores.
  function automatic req_t make_req(input logic [1:0] cmd, input int addr,
                                    input logic [31:0] data, input int seg,
                                    input logic [31:0] xq);
    req_t r;
    r = req_t'(REQ_W'({$urandom, $urandom, $urandom}));
    r.cmd = cmd;
    if (cmd != CMD_EVAL) begin
      r.word_addr = 7'(addr);
      r.word_data = data;
    end else begin
      r.segment = 6'(seg);
      r.x_query = xq;
    end
    return r;
  endfunction

  task automatic write_segment(input int seg, input logic [31:0] xw[4], input logic [31:0] yw[4]);
    for (int k = 0; k < 4; k++) begin
      send_item(make_req(CMD_WRX, (seg * 3 + k) % TAB_WORDS, xw[k], 0, 0));
      send_item(make_req(CMD_WRY, (seg * 3 + k) % TAB_WORDS, yw[k], 0, 0));
    end
  endtask

  // Write a segment whose last x lies above its first, with the inner x words between them.
  task automatic write_rising_segment(input int seg);
    logic [31:0] xw[4];
    logic [31:0] yw[4];
    int span;
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'h00ffffff) : $urandom_range(1, 32'h0004ffff);
    xw[0] = 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
    xw[3] = xw[0] + 32'(span);
    xw[1] = xw[0] + 32'($urandom_range(0, span));
    xw[2] = xw[0] + 32'($urandom_range(0, span));
    for (int k = 0; k < 4; k++) begin
      yw[k] = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000);
    end
    write_segment(seg, xw, yw);
  endtask

  // Every table word gets a random value so that no read finds an unwritten entry.
  task automatic test_table_load();
    for (int a = 0; a < TAB_WORDS; a++) begin
      send_item(make_req(CMD_WRX, a, $urandom, 0, 0));
      send_item(make_req(CMD_WRY, a, $urandom, 0, 0));
    end
  endtask

  // Extremes, flat segments, wrapped segments and the unused command.
  task automatic test_directed();
    logic [31:0] xw[4];
    logic [31:0] yw[4];
    // Straight x ramp with extreme y words.
    xw = '{32'h0, 32'h10000, 32'h20000, 32'h30000};
    yw = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    write_segment(0, xw, yw);
    send_item(make_req(CMD_EVAL, 0, 0, 0, 32'h0));
    send_item(make_req(CMD_EVAL, 0, 0, 0, 32'h18000));
    send_item(make_req(CMD_EVAL, 0, 0, 0, 32'h7fffffff));
    send_item(make_req(CMD_EVAL, 0, 0, 0, 32'h80000000));
    // A flat x segment hits both the zero chord and the zero slope.
    xw = '{32'h50000, 32'h50000, 32'h50000, 32'h50000};
    send_item(make_req(CMD_WRX, 3, xw[0], 0, 0));
    send_item(make_req(CMD_WRX, 4, xw[1], 0, 0));
    send_item(make_req(CMD_WRX, 5, xw[2], 0, 0));
    send_item(make_req(CMD_WRX, 6, xw[3], 0, 0));
    send_item(make_req(CMD_EVAL, 0, 0, 1, 32'h60000));
    // Segment 63, the last, and segment 42 both wrap past the end of the table.
    send_item(make_req(CMD_EVAL, 0, 0, 63, $urandom));
    send_item(make_req(CMD_EVAL, 0, 0, 42, $urandom));
    // Extreme x words on segment two.
    send_item(make_req(CMD_WRX, 7, 32'h7fffffff, 0, 0));
    send_item(make_req(CMD_WRX, 8, 32'h80000000, 0, 0));
    send_item(make_req(CMD_EVAL, 0, 0, 2, 32'h0));
    send_item(make_req(CMD_EVAL, 0, 0, 2, 32'h80000000));
    // The unused command must give nothing.
    send_item(make_req(CMD_UNUSED, 0, 0, 0, 0));
  endtask

  // Mostly well-formed segments with in-range queries, plus noise.
  task automatic test_random();
    int seg;
    int pick;
    longint lo;
    longint hi;
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      pick = $urandom_range(0, 99);
      seg = $urandom_range(0, 63);
      if (pick < 12) begin
        write_rising_segment(seg);
        n += 8;
      end else if (pick < 75) begin
        lo = x_tab[(seg * 3) % TAB_WORDS];
        hi = x_tab[(seg * 3 + 3) % TAB_WORDS];
        send_item(make_req(CMD_EVAL, 0, 0, seg,
                           32'(lo + ((hi - lo) * $urandom_range(0, 1100)) / 1024)));
        n++;
      end else if (pick < 85) begin
        send_item(make_req(CMD_EVAL, 0, 0, seg, $urandom));
        n++;
      end else if (pick < 97) begin
        send_item(make_req(($urandom_range(0, 1) == 0) ? CMD_WRX : CMD_WRY,
                           $urandom_range(0, 127), $urandom, 0, 0));
        n++;
      end else begin
        send_item(make_req(CMD_UNUSED, 0, 0, 0, 0));
      end
    end
  endtask

  // Receiver stall pattern: quiet spells, random spells and a fixed cadence.
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case ((stall_tick / 96) % 3)
      0: begin
        rsp_stall <= 1'b0;
      end
      1: begin
        rsp_stall <= ($urandom_range(0, 1) == 1);
      end
      default: begin
        rsp_stall <= ((stall_tick % 7) < 3);
      end
    endcase
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_points.size() == 0) begin
        $error("unexpected result y_value %0d degenerate %0d", rsp.y_value, rsp.degenerate);
        fail_count++;
      end else begin
        if (rsp.y_value !== pending_points[0].y_value) begin
          $error("y_value expected %0d actual %0d", pending_points[0].y_value, rsp.y_value);
          fail_count++;
        end
        if (rsp.degenerate !== pending_points[0].degenerate) begin
          $error("degenerate expected %0d actual %0d", pending_points[0].degenerate,
                 rsp.degenerate);
          fail_count++;
        end
        void'(pending_points.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    rsp_stall = 1'b0;
    req = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_table_load();
    test_directed();
    test_random();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_points.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/wbc_pkg.sv
rtl/wbc_div.sv
rtl/wbc_newton.sv
rtl/weighted_bezier_curve_eval.sv
bench/tb_weighted_bezier_curve_eval.sv
